// ===== rtl/mcbf_pkg.sv =====
`default_nettype none

package mcbf_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int DEPTH_DEF    = 16;

   localparam int BYTE_W   = 8;
   localparam int CHAN_W   = 2;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 5;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] channel;
      logic [BYTE_W-1:0] data_in;
      logic              last_in;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_out;
      logic [STATUS_W-1:0] status;
      logic [LEVEL_W-1:0]  fill_level;
      logic                last_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/mcbf_ram.sv =====
`default_nettype none

module mcbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_byte_fifo.sv =====
`default_nettype none
// multi-channel byte fifo: one push or pop request per cycle on any channel
// the result strobe is registered and comes in the cycle after the request is taken
// throughput: one request every cycle, busy is never raised
// popped byte comes from the registered read port of the byte memory
// reset (synchronous, active high) empties every channel; buffer bytes are not cleared

module multi_channel_byte_fifo #(
   parameter int CHANNELS = mcbf_pkg::CHANNELS_DEF,
   parameter int DEPTH    = mcbf_pkg::DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mcbf_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output mcbf_pkg::rsp_type      rsp_data
);

   import mcbf_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int LVL_W  = PTR_W + 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHX_W  = ((CH_W > CHAN_W) ? CH_W : CHAN_W) + 1;
   localparam int ENTRIES = CHANNELS * DEPTH;
   localparam int ADDR_W = $clog2(ENTRIES);

   logic [PTR_W-1:0]    rd_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]    wr_ptr_ff [CHANNELS];
   logic [CHANNELS-1:0] full_ff;

   logic                rsp_valid_ff;
   logic                pop_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [LVL_W-1:0]    lvl_ff;
   logic                last_ff;

   logic [CHX_W-1:0]    ch_ext;
   logic [CH_W-1:0]     ch_idx;
   logic                ch_ok;
   logic                is_write;
   logic [PTR_W-1:0]    cur_rp;
   logic [PTR_W-1:0]    cur_wp;
   logic                cur_full;
   logic [LVL_W-1:0]    cur_lvl;
   logic [PTR_W-1:0]    rp_nxt;
   logic [PTR_W-1:0]    wp_nxt;
   logic                do_pop;
   logic                do_push;
   logic [STATUS_W-1:0] status_in;
   logic [LVL_W-1:0]    lvl_in;
   logic [ADDR_W-1:0]   ch_base;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]   ram_rd_data;

   assign busy = 1'b0;

   always_comb begin
      ch_ext   = CHX_W'(req_data.channel);
      ch_idx   = ch_ext[CH_W-1:0];
      ch_ok    = (ch_ext < CHX_W'(CHANNELS));
      is_write = (req_data.op == OP_WRITE);
      cur_rp   = rd_ptr_ff[ch_idx];
      cur_wp   = wr_ptr_ff[ch_idx];
      cur_full = full_ff[ch_idx];
      if (cur_full) begin
         cur_lvl = LVL_W'(DEPTH);
      end else if (cur_wp >= cur_rp) begin
         cur_lvl = {1'b0, cur_wp} - {1'b0, cur_rp};
      end else begin
         cur_lvl = {1'b0, cur_wp} + LVL_W'(DEPTH) - {1'b0, cur_rp};
      end
      rp_nxt = (cur_rp == PTR_W'(DEPTH - 1)) ? '0 : cur_rp + 1'b1;
      wp_nxt = (cur_wp == PTR_W'(DEPTH - 1)) ? '0 : cur_wp + 1'b1;

      do_pop  = start && ch_ok && !is_write && (cur_lvl != '0);
      do_push = start && ch_ok && is_write && !cur_full;

      if (!ch_ok) begin
         status_in = is_write ? ST_FULL : ST_EMPTY;
      end else if (is_write) begin
         status_in = cur_full ? ST_FULL : ST_DONE;
      end else begin
         status_in = (cur_lvl == '0) ? ST_EMPTY : ST_DONE;
      end

      if (!ch_ok) begin
         lvl_in = '0;
      end else if (do_pop) begin
         lvl_in = cur_lvl - 1'b1;
      end else if (do_push) begin
         lvl_in = cur_lvl + 1'b1;
      end else begin
         lvl_in = cur_lvl;
      end

      ch_base = ADDR_W'(ch_idx) * ADDR_W'(DEPTH);
      wr_addr = ch_base + ADDR_W'(cur_wp);
      rd_addr = ch_base + ADDR_W'(cur_rp);
   end

   // channel pointers and full marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
         end
         full_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff[ch_idx] <= wp_nxt;
            full_ff[ch_idx]   <= (wp_nxt == cur_rp);
         end
         if (do_pop) begin
            rd_ptr_ff[ch_idx] <= rp_nxt;
            full_ff[ch_idx]   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pop_ff    <= do_pop;
         status_ff <= status_in;
         lvl_ff    <= lvl_in;
         last_ff   <= req_data.last_in;
      end
   end

   mcbf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data (req_data.data_in),
      .rd_en   (do_pop),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe = rsp_valid_ff;

   always_comb begin
      rsp_data.data_out   = pop_ff ? ram_rd_data : '0;
      rsp_data.status     = status_ff;
      rsp_data.fill_level = LEVEL_W'(lvl_ff);
      rsp_data.last_out   = last_ff;
   end

   // one response for every request, in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid_ff == $past(start)))
      else $error("response strobe does not follow request");

   // a full refusal only answers a write, an empty refusal only a read
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> ($past(req_data.op) == OP_WRITE))
      else $error("full status on a read request");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> ($past(req_data.op) == OP_READ))
      else $error("empty status on a write request");

   // a channel marked full has equal pointers
   for (genvar g = 0; g < CHANNELS; g++) begin : g_full_chk
      assert property (@(posedge clock) disable iff (reset)
         full_ff[g] |-> (wr_ptr_ff[g] == rd_ptr_ff[g]))
         else $error("full mark with unequal pointers");
   end

endmodule

`default_nettype wire
